[design/e2r_pkg.sv]
// Shared types, constants and helpers for the Euler angle to rotation matrix block.
package e2r_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int IN_W            = 18;
    localparam int OUT_W           = 16;

    // Angle reduction constants, degrees scaled by the fraction bits
    localparam int FULL_DEG_I = 360 << ANGLE_FRAC_BITS;
    localparam int RED_W      = $clog2(FULL_DEG_I);
    localparam int REM_W      = $clog2((45 << ANGLE_FRAC_BITS) + 1);
    localparam logic [RED_W-1:0] QUARTER_DEG = RED_W'(90 << ANGLE_FRAC_BITS);
    localparam logic [RED_W-1:0] EIGHTH_DEG  = RED_W'(45 << ANGLE_FRAC_BITS);

    // round(pi/180 * 2^30)
    localparam logic [24:0] RAD_K = 25'd18740330;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Taylor step divisors; each divide is a reciprocal multiply plus one fixup
    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;
    localparam logic [7:0] SIN_K [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_K [COS_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam int SIN_S [SIN_STEPS] = '{38, 38, 37, 36, 34};
    localparam int COS_S [COS_STEPS] = '{39, 38, 37, 36, 35, 32};
    localparam logic [31:0] SIN_M [SIN_STEPS] = '{
        32'((64'd1 << 38) / 64'd110),
        32'((64'd1 << 38) / 64'd72),
        32'((64'd1 << 37) / 64'd42),
        32'((64'd1 << 36) / 64'd20),
        32'((64'd1 << 34) / 64'd6)
    };
    localparam logic [31:0] COS_M [COS_STEPS] = '{
        32'((64'd1 << 39) / 64'd132),
        32'((64'd1 << 38) / 64'd90),
        32'((64'd1 << 37) / 64'd56),
        32'((64'd1 << 36) / 64'd30),
        32'((64'd1 << 35) / 64'd12),
        32'((64'd1 << 32) / 64'd2)
    };

    // Back pipeline depth: sine/cosine unit plus matrix stages
    localparam int SC_LAT   = 23;
    localparam int MX_LAT   = 6;
    localparam int BACK_LAT = SC_LAT + MX_LAT;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0]       quad;
        logic             swap;
        logic [REM_W-1:0] rem;
    } angle_t;

    typedef struct packed {
        angle_t yaw;
        angle_t pitch;
        angle_t roll;
    } item_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } fifo_stat_t;

    typedef struct packed {
        logic [OUT_W-1:0] m22;
        logic [OUT_W-1:0] m21;
        logic [OUT_W-1:0] m20;
        logic [OUT_W-1:0] m12;
        logic [OUT_W-1:0] m11;
        logic [OUT_W-1:0] m10;
        logic [OUT_W-1:0] m02;
        logic [OUT_W-1:0] m01;
        logic [OUT_W-1:0] m00;
    } matrix_t;

    // Round a Q4.60 magnitude product back to Q2.30
    function automatic logic [30:0] rnd30(input logic [60:0] p);
        logic [60:0] s;
        s = p + (61'd1 << 29);
        return 31'(s >> 30);
    endfunction

endpackage

[design/e2r_front.sv]
// Front end: accepts angle triples and reduces each angle to quadrant, mirror and octant remainder.
module e2r_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [e2r_pkg::IN_W-1:0]   roll_deg,
    input  logic [e2r_pkg::IN_W-1:0]   pitch_deg,
    input  logic [e2r_pkg::IN_W-1:0]   yaw_deg,
    input  e2r_pkg::fifo_stat_t        fstat,
    output logic                       push,
    output e2r_pkg::item_t             item
);

    logic           f_valid_reg, f_valid_next;
    e2r_pkg::item_t f_item_reg;
    e2r_pkg::item_t f_item_next;
    logic           accept;

    function automatic e2r_pkg::angle_t reduce(input logic [e2r_pkg::IN_W-1:0] raw);
        logic signed [19:0]                 a, ap1, ap2, am1, sel;
        logic [e2r_pkg::RED_W-1:0]          red;
        logic [e2r_pkg::RED_W-1:0]          base;
        logic [e2r_pkg::RED_W-1:0]          rem;
        e2r_pkg::angle_t                    r;
        a   = 20'(signed'(raw));
        ap1 = a + 20'(e2r_pkg::FULL_DEG_I);
        ap2 = a + 20'(2 * e2r_pkg::FULL_DEG_I);
        am1 = a - 20'(e2r_pkg::FULL_DEG_I);
        if (a < 0)
        begin
            sel = (ap1 < 0) ? ap2 : ap1;
        end
        else
        begin
            sel = (a >= 20'(e2r_pkg::FULL_DEG_I)) ? am1 : a;
        end
        red = e2r_pkg::RED_W'(sel);
        if (red >= 3 * e2r_pkg::QUARTER_DEG)
        begin
            r.quad = 2'd3;
            base   = e2r_pkg::RED_W'(3 * e2r_pkg::QUARTER_DEG);
        end
        else if (red >= 2 * e2r_pkg::QUARTER_DEG)
        begin
            r.quad = 2'd2;
            base   = e2r_pkg::RED_W'(2 * e2r_pkg::QUARTER_DEG);
        end
        else if (red >= e2r_pkg::QUARTER_DEG)
        begin
            r.quad = 2'd1;
            base   = e2r_pkg::QUARTER_DEG;
        end
        else
        begin
            r.quad = 2'd0;
            base   = '0;
        end
        rem    = red - base;
        r.swap = rem > e2r_pkg::EIGHTH_DEG;
        r.rem  = r.swap ? e2r_pkg::REM_W'(e2r_pkg::QUARTER_DEG - rem) : e2r_pkg::REM_W'(rem);
        return r;
    endfunction

    assign s_tready = !f_valid_reg || !fstat.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = f_valid_reg && !fstat.full;
    assign item     = f_item_reg;

    always_comb
    begin
        f_item_next.roll  = reduce(roll_deg);
        f_item_next.pitch = reduce(pitch_deg);
        f_item_next.yaw   = reduce(yaw_deg);
        if (accept)
            f_valid_next = 1'b1;
        else if (push)
            f_valid_next = 1'b0;
        else
            f_valid_next = f_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            f_item_reg <= f_item_next;
    end

endmodule

[design/e2r_fifo.sv]
// Short queue between front end and back end.
module e2r_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  e2r_pkg::item_t       din,
    input  logic                 pop,
    output e2r_pkg::item_t       dout,
    output e2r_pkg::fifo_stat_t  fstat
);

    e2r_pkg::item_t                 mem_reg [e2r_pkg::FIFO_DEPTH];
    logic [e2r_pkg::FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [e2r_pkg::FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [e2r_pkg::FIFO_AW:0]      count_reg, count_next;
    logic                           do_push, do_pop;

    assign fstat.full     = count_reg == (e2r_pkg::FIFO_AW+1)'(e2r_pkg::FIFO_DEPTH);
    assign fstat.nonempty = count_reg != '0;
    assign do_push        = push && !fstat.full;
    assign do_pop         = pop && fstat.nonempty;
    assign dout           = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

[design/e2r_sincos.sv]
// Pipelined sine/cosine of one reduced angle, Q2.30 signed results.
module e2r_sincos (
    input  logic                clk,
    input  logic                en,
    input  e2r_pkg::angle_t     ang,
    output logic signed [31:0]  sin_q30,
    output logic signed [31:0]  cos_q30
);

    localparam int QS_LEN = e2r_pkg::SC_LAT - 1;
    localparam int XD_LEN = 17;
    localparam int X2_LEN = 3 * e2r_pkg::COS_STEPS - 3;

    logic [38:0] prodx_reg;
    logic [29:0] x_reg;
    logic [59:0] xx_reg;
    logic [29:0] x2_reg;
    logic [2:0]  qs_reg [QS_LEN];
    logic [29:0] xd_reg [XD_LEN];
    logic [29:0] x2d_reg [X2_LEN];

    logic [60:0] ca_p_reg    [e2r_pkg::COS_STEPS];
    logic [30:0] cb_v_reg    [e2r_pkg::COS_STEPS];
    logic [62:0] cb_prod_reg [e2r_pkg::COS_STEPS];
    logic [30:0] cc_t_reg    [e2r_pkg::COS_STEPS];
    logic [60:0] sa_p_reg    [e2r_pkg::SIN_STEPS];
    logic [30:0] sb_v_reg    [e2r_pkg::SIN_STEPS];
    logic [62:0] sb_prod_reg [e2r_pkg::SIN_STEPS];
    logic [30:0] sc_t_reg    [e2r_pkg::SIN_STEPS];

    logic [60:0] sp_reg;
    logic [30:0] s_reg, s2_reg;
    logic signed [31:0] sin_reg, cos_reg;

    // Front of the unit: radians, then x squared
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prodx_reg <= 39'(ang.rem) * 39'(e2r_pkg::RAD_K);
            x_reg     <= 30'((prodx_reg + (39'd1 << (e2r_pkg::ANGLE_FRAC_BITS - 1)))
                             >> e2r_pkg::ANGLE_FRAC_BITS);
            xx_reg    <= 60'(x_reg) * 60'(x_reg);
            x2_reg    <= 30'(e2r_pkg::rnd30(61'(xx_reg)));
            qs_reg[0] <= {ang.quad, ang.swap};
            xd_reg[0] <= x_reg;
            x2d_reg[0] <= x2_reg;
            for (int i = 1; i < QS_LEN; i++)
                qs_reg[i] <= qs_reg[i-1];
            for (int i = 1; i < XD_LEN; i++)
                xd_reg[i] <= xd_reg[i-1];
            for (int i = 1; i < X2_LEN; i++)
                x2d_reg[i] <= x2d_reg[i-1];
        end
    end

    // Cosine series: three stages per Horner step
    for (genvar g = 0; g < e2r_pkg::COS_STEPS; g++)
    begin : g_cos
        logic [29:0] x2_in;
        logic [30:0] t_in;
        logic [30:0] v;
        logic [30:0] q0;
        logic [39:0] qk;
        logic [39:0] r;
        if (g == 0)
        begin : g_first
            assign x2_in = x2_reg;
            assign t_in  = e2r_pkg::Q30_ONE;
        end
        else
        begin : g_next
            assign x2_in = x2d_reg[3*g-1];
            assign t_in  = cc_t_reg[g-1];
        end
        assign v  = e2r_pkg::rnd30(ca_p_reg[g]);
        assign q0 = 31'(cb_prod_reg[g] >> e2r_pkg::COS_S[g]);
        assign qk = 40'(q0) * 40'(e2r_pkg::COS_K[g]);
        assign r  = 40'(cb_v_reg[g]) - qk;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ca_p_reg[g]    <= 61'(x2_in) * 61'(t_in);
                cb_v_reg[g]    <= v;
                cb_prod_reg[g] <= 63'(v) * 63'(e2r_pkg::COS_M[g]);
                cc_t_reg[g]    <= e2r_pkg::Q30_ONE
                                  - (q0 + 31'(r >= 40'(e2r_pkg::COS_K[g])));
            end
        end
    end

    // Sine series, same step structure
    for (genvar g = 0; g < e2r_pkg::SIN_STEPS; g++)
    begin : g_sin
        logic [29:0] x2_in;
        logic [30:0] t_in;
        logic [30:0] v;
        logic [30:0] q0;
        logic [39:0] qk;
        logic [39:0] r;
        if (g == 0)
        begin : g_first
            assign x2_in = x2_reg;
            assign t_in  = e2r_pkg::Q30_ONE;
        end
        else
        begin : g_next
            assign x2_in = x2d_reg[3*g-1];
            assign t_in  = sc_t_reg[g-1];
        end
        assign v  = e2r_pkg::rnd30(sa_p_reg[g]);
        assign q0 = 31'(sb_prod_reg[g] >> e2r_pkg::SIN_S[g]);
        assign qk = 40'(q0) * 40'(e2r_pkg::SIN_K[g]);
        assign r  = 40'(sb_v_reg[g]) - qk;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sa_p_reg[g]    <= 61'(x2_in) * 61'(t_in);
                sb_v_reg[g]    <= v;
                sb_prod_reg[g] <= 63'(v) * 63'(e2r_pkg::SIN_M[g]);
                sc_t_reg[g]    <= e2r_pkg::Q30_ONE
                                  - (q0 + 31'(r >= 40'(e2r_pkg::SIN_K[g])));
            end
        end
    end

    // sin = x * t, one spare stage to line up with cosine, then octant unfold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg <= 61'(xd_reg[XD_LEN-1]) * 61'(sc_t_reg[e2r_pkg::SIN_STEPS-1]);
            s_reg  <= e2r_pkg::rnd30(sp_reg);
            s2_reg <= s_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [31:0] so, co, sw, cw;
        so = signed'(32'(s2_reg));
        co = signed'(32'(cc_t_reg[e2r_pkg::COS_STEPS-1]));
        sw = qs_reg[QS_LEN-1][0] ? co : so;
        cw = qs_reg[QS_LEN-1][0] ? so : co;
        if (en)
        begin
            case (qs_reg[QS_LEN-1][2:1])
                2'd0:
                begin
                    sin_reg <= sw;
                    cos_reg <= cw;
                end
                2'd1:
                begin
                    sin_reg <= cw;
                    cos_reg <= -sw;
                end
                2'd2:
                begin
                    sin_reg <= -sw;
                    cos_reg <= -cw;
                end
                default:
                begin
                    sin_reg <= -cw;
                    cos_reg <= sw;
                end
            endcase
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

[design/e2r_back.sv]
// Back end: three sine/cosine units, matrix products, output rounding and the result register.
module e2r_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  e2r_pkg::item_t       head,
    input  e2r_pkg::fifo_stat_t  fstat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output e2r_pkg::matrix_t     result
);

    localparam int I_CYCP = 0;
    localparam int I_SYCP = 1;
    localparam int I_CYSP = 2;
    localparam int I_SYSP = 3;
    localparam int I_SYCR = 4;
    localparam int I_SYSR = 5;
    localparam int I_CYCR = 6;
    localparam int I_CYSR = 7;
    localparam int I_CPSR = 8;
    localparam int I_CPCR = 9;
    localparam int NP1    = 10;
    localparam int J_CYSPSR = 0;
    localparam int J_CYSPCR = 1;
    localparam int J_SYSPSR = 2;
    localparam int J_SYSPCR = 3;
    localparam int NP2      = 4;

    logic                       adv;
    logic [e2r_pkg::BACK_LAT-1:0] vld_reg;
    logic signed [31:0] sr, cr, sp, cp, sy, cy;

    logic signed [31:0] opa [NP1];
    logic signed [31:0] opb [NP1];
    logic               p1_neg_reg [NP1];
    logic [60:0]        p1_mag_reg [NP1];
    logic signed [31:0] r2_reg [NP1];
    logic signed [31:0] sr1_reg, cr1_reg, sr2_reg, cr2_reg;
    logic signed [31:0] spd_reg [4];
    logic signed [31:0] op2a [NP2];
    logic signed [31:0] op2b [NP2];
    logic               p3_neg_reg [NP2];
    logic [60:0]        p3_mag_reg [NP2];
    logic signed [31:0] r3_reg [NP1];
    logic signed [31:0] r4_reg [NP2];
    logic signed [31:0] r4a_reg [NP1];
    logic signed [32:0] e_reg [9];
    e2r_pkg::matrix_t   out_reg;

    function automatic logic [30:0] mag31(input logic signed [31:0] a);
        logic signed [31:0] n;
        n = a[31] ? -a : a;
        return 31'(n);
    endfunction

    function automatic logic signed [31:0] apply(input logic neg, input logic [30:0] m);
        logic signed [31:0] v;
        v = signed'(32'(m));
        return neg ? -v : v;
    endfunction

    // Q2.30 to Q2.OUT_FRAC_BITS, half away from zero, clamp at one
    function automatic logic [e2r_pkg::OUT_W-1:0] to_out(input logic signed [32:0] v);
        localparam int SH = 30 - e2r_pkg::OUT_FRAC_BITS;
        logic [32:0] m;
        logic [32:0] r;
        logic [32:0] lim;
        m   = v[32] ? 33'(-v) : 33'(v);
        r   = (m + (33'd1 << (SH - 1))) >> SH;
        lim = 33'd1 << e2r_pkg::OUT_FRAC_BITS;
        if (r > lim)
            r = lim;
        if (v[32])
            r = -r;
        return e2r_pkg::OUT_W'(r);
    endfunction

    assign adv      = !m_tvalid || m_tready;
    assign pop      = adv && fstat.nonempty;
    assign m_tvalid = vld_reg[e2r_pkg::BACK_LAT-1];
    assign result   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[e2r_pkg::BACK_LAT-2:0], fstat.nonempty};
    end

    e2r_sincos u_roll (
        .clk     (clk),
        .en      (adv),
        .ang     (head.roll),
        .sin_q30 (sr),
        .cos_q30 (cr)
    );

    e2r_sincos u_pitch (
        .clk     (clk),
        .en      (adv),
        .ang     (head.pitch),
        .sin_q30 (sp),
        .cos_q30 (cp)
    );

    e2r_sincos u_yaw (
        .clk     (clk),
        .en      (adv),
        .ang     (head.yaw),
        .sin_q30 (sy),
        .cos_q30 (cy)
    );

    always_comb
    begin
        opa[I_CYCP] = cy;  opb[I_CYCP] = cp;
        opa[I_SYCP] = sy;  opb[I_SYCP] = cp;
        opa[I_CYSP] = cy;  opb[I_CYSP] = sp;
        opa[I_SYSP] = sy;  opb[I_SYSP] = sp;
        opa[I_SYCR] = sy;  opb[I_SYCR] = cr;
        opa[I_SYSR] = sy;  opb[I_SYSR] = sr;
        opa[I_CYCR] = cy;  opb[I_CYCR] = cr;
        opa[I_CYSR] = cy;  opb[I_CYSR] = sr;
        opa[I_CPSR] = cp;  opb[I_CPSR] = sr;
        opa[I_CPCR] = cp;  opb[I_CPCR] = cr;
        op2a[J_CYSPSR] = r2_reg[I_CYSP];  op2b[J_CYSPSR] = sr2_reg;
        op2a[J_CYSPCR] = r2_reg[I_CYSP];  op2b[J_CYSPCR] = cr2_reg;
        op2a[J_SYSPSR] = r2_reg[I_SYSP];  op2b[J_SYSPSR] = sr2_reg;
        op2a[J_SYSPCR] = r2_reg[I_SYSP];  op2b[J_SYSPCR] = cr2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // first-level products and their rounding
            for (int i = 0; i < NP1; i++)
            begin
                p1_neg_reg[i] <= opa[i][31] ^ opb[i][31];
                p1_mag_reg[i] <= 61'(mag31(opa[i])) * 61'(mag31(opb[i]));
                r2_reg[i]     <= apply(p1_neg_reg[i], e2r_pkg::rnd30(p1_mag_reg[i]));
                r3_reg[i]     <= r2_reg[i];
                r4a_reg[i]    <= r3_reg[i];
            end
            sr1_reg <= sr;
            cr1_reg <= cr;
            sr2_reg <= sr1_reg;
            cr2_reg <= cr1_reg;
            spd_reg[0] <= sp;
            for (int i = 1; i < 4; i++)
                spd_reg[i] <= spd_reg[i-1];
            // triple products through the rounded yaw-pitch terms
            for (int j = 0; j < NP2; j++)
            begin
                p3_neg_reg[j] <= op2a[j][31] ^ op2b[j][31];
                p3_mag_reg[j] <= 61'(mag31(op2a[j])) * 61'(mag31(op2b[j]));
                r4_reg[j]     <= apply(p3_neg_reg[j], e2r_pkg::rnd30(p3_mag_reg[j]));
            end
            e_reg[0] <= 33'(r4a_reg[I_CYCP]);
            e_reg[1] <= 33'(r4_reg[J_CYSPSR]) - 33'(r4a_reg[I_SYCR]);
            e_reg[2] <= 33'(r4a_reg[I_SYSR]) + 33'(r4_reg[J_CYSPCR]);
            e_reg[3] <= 33'(r4a_reg[I_SYCP]);
            e_reg[4] <= 33'(r4a_reg[I_CYCR]) + 33'(r4_reg[J_SYSPSR]);
            e_reg[5] <= 33'(r4_reg[J_SYSPCR]) - 33'(r4a_reg[I_CYSR]);
            e_reg[6] <= -33'(spd_reg[3]);
            e_reg[7] <= 33'(r4a_reg[I_CPSR]);
            e_reg[8] <= 33'(r4a_reg[I_CPCR]);
            out_reg.m00 <= to_out(e_reg[0]);
            out_reg.m01 <= to_out(e_reg[1]);
            out_reg.m02 <= to_out(e_reg[2]);
            out_reg.m10 <= to_out(e_reg[3]);
            out_reg.m11 <= to_out(e_reg[4]);
            out_reg.m12 <= to_out(e_reg[5]);
            out_reg.m20 <= to_out(e_reg[6]);
            out_reg.m21 <= to_out(e_reg[7]);
            out_reg.m22 <= to_out(e_reg[8]);
        end
    end

endmodule

[design/euler_to_rotation_matrix.sv]
// Top level: roll/pitch/yaw angles to ZYX rotation matrix, streaming in and out.
//
// Input channel (s_*): one transaction carries roll, pitch and yaw in degrees,
// each 18-bit two's complement with 8 fraction bits. Any pattern is taken and
// wraps modulo 360 degrees.
// Output channel (m_*): one transaction per input transaction, in order, with the
// nine matrix entries R = Rz(yaw)*Ry(pitch)*Rx(roll) as signed Q2.14, clamped
// to +/-1.0.
// Throughput: one transaction per cycle sustained while m_tready is held high. Every
// divide, multiply and series step is its own pipeline stage, so nothing iterates.
// Path to output valid: the front register loads at the accepting edge, then the
// queue write, 23 sine/cosine stages and 6 matrix stages follow; the 6-step
// cosine series sets the sine/cosine depth.
// Stalls: the back pipeline freezes as a whole while m_tvalid is high and
// m_tready is low; the front keeps taking transactions into its register and a
// 4-entry queue until both are full, then drops s_tready.
// Reset: asynchronous, clears all valid state; no transaction is in flight after
// reset, and the data registers are not cleared.
module euler_to_rotation_matrix (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // [17:0] roll_deg, [35:18] pitch_deg, [53:36] yaw_deg, [55:54] zero
    input  logic [55:0]   s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // [15:0] m00, [31:16] m01, [47:32] m02, [63:48] m10, [79:64] m11,
    // [95:80] m12, [111:96] m20, [127:112] m21, [143:128] m22
    output logic [143:0]  m_tdata
);

    logic                 fifo_push;
    logic                 back_pop;
    e2r_pkg::item_t       front_item;
    e2r_pkg::item_t       head_item;
    e2r_pkg::fifo_stat_t  fstat;
    e2r_pkg::matrix_t     result;

    e2r_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .roll_deg  (s_tdata[17:0]),
        .pitch_deg (s_tdata[35:18]),
        .yaw_deg   (s_tdata[53:36]),
        .fstat     (fstat),
        .push      (fifo_push),
        .item      (front_item)
    );

    e2r_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .din   (front_item),
        .pop   (back_pop),
        .dout  (head_item),
        .fstat (fstat)
    );

    e2r_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_item),
        .fstat    (fstat),
        .pop      (back_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tdata = result;

    // back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) back_pop |-> fstat.nonempty)
        else $error("pop from empty queue");

    // a stalled result freezes the back end, so nothing leaves the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !back_pop)
        else $error("queue popped while output stalled");

    // input backpressure only comes from a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !s_tready |-> fstat.full)
        else $error("s_tready low with room in queue");

    // a pending front item with a full queue is not lost
    assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tready && !back_pop) |=> !s_tready)
        else $error("front item dropped while queue full");

endmodule
